FILE: hw/rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

   localparam int LKV_ENTRIES = 16;
   localparam int CAP_W       = 5;
   localparam int DATA_W      = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef struct packed {
      logic                     operation;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] write_value;
   } lkv_req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } lkv_rsp_type;

   // broadcast to every cell in the update cycle
   typedef struct packed {
      logic              upd_hit;    // set on a stored key
      logic              ins_evict;  // set on a new key, row full
      logic              ins_fill;   // set on a new key, free cell left
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } lkv_ctrl_type;

   // lookup result rippling along the row
   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] value;
   } lkv_link_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache.sv
// An accepted request is registered and the state moves to run; in the single update cycle, once
//   the result register is free or being emptied, the cell row is compared and updated and the
//   result registered. No new request is taken before that update, whose ranks and fill count it needs.
// A new request is taken while an earlier result still waits on rsp_stall.
// Reset (synchronous, active high) clears valid marks, ranks, fill count and handshake
//   state, and sets capacity to 16; stored keys and values are not cleared.
`default_nettype none

module lru_key_value_cache #(
   parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire lkv_pkg::lkv_req_type      req_payload,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      lkv_pkg::lkv_rsp_type      rsp_payload,
   input  wire logic                      csr_write_enable,
   input  wire logic [lkv_pkg::CAP_W-1:0] csr_write_data
);
   import lkv_pkg::*;

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   lkv_req_type       req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lkv_rsp_type       rsp_ff, rsp_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              req_take;
   logic              fire;     // the update cycle of a transaction
   logic              full;
   logic [FILL_W-1:0] fill_dec;
   logic [RANK_W-1:0] victim_rank;
   lkv_ctrl_type      ctrl;

   // row of cells: lookup result, matched rank and valid mark ripple left to right
   lkv_link_type      link [ENTRIES+1];
   logic [RANK_W-1:0] rank_link [ENTRIES+1];
   logic              valid_link [ENTRIES+1];
   logic [ENTRIES-1:0] valid_vec;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   // result register free, or being emptied this cycle
   assign fire        = (state_ff == ST_RUN) && (!rsp_valid_ff || !rsp_stall);

   // Capacity zero counts as one; capacity above the row size counts as the row size.
   assign full = ((CMP_W'(fill_ff) >= CMP_W'(cap_ff)) && (fill_ff != '0))
              || (fill_ff == FILL_W'(ENTRIES));

   // valid ranks are unique and run 0 .. fill-1, so the least recent holds fill-1
   assign fill_dec    = FILL_W'(fill_ff - 1'b1);
   assign victim_rank = fill_dec[RANK_W-1:0];

   assign link[0]       = '0;
   assign rank_link[0]  = '0;
   assign valid_link[0] = 1'b1;

   assign ctrl.key       = req_ff.key;
   assign ctrl.value     = req_ff.write_value;
   assign ctrl.upd_hit   = fire && (req_ff.operation == OP_SET) && link[ENTRIES].hit;
   assign ctrl.ins_evict = fire && (req_ff.operation == OP_SET) && !link[ENTRIES].hit && full;
   assign ctrl.ins_fill  = fire && (req_ff.operation == OP_SET) && !link[ENTRIES].hit && !full;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkv_cell #(
         .RANK_W (RANK_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .touch_rank  (rank_link[ENTRIES]),
         .victim_rank (victim_rank),
         .link_in     (link[i]),
         .rank_prev   (rank_link[i]),
         .prev_valid  (valid_link[i]),
         .link_out    (link[i+1]),
         .rank_out    (rank_link[i+1]),
         .valid_out   (valid_link[i+1])
      );
      assign valid_vec[i] = valid_link[i+1];
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cap_in       = cap_ff;
      fill_in      = fill_ff;

      if (csr_write_enable) begin
         cap_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in   = req_payload;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (fire) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_in.hit     = link[ENTRIES].hit;
               // all ones on a miss and on every set
               rsp_in.read_value = ((req_ff.operation == OP_GET) && link[ENTRIES].hit)
                                 ? link[ENTRIES].value : '1;
               if (ctrl.ins_fill) begin
                  fill_in = FILL_W'(fill_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // fill count never passes the row size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(ENTRIES))
      else $error("fill count beyond row size");

   // valid marks form a prefix; their count is checked against the fill count
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("valid marks disagree with fill count");

   // an accepted request is worked on in the next cycle
   a_take_run: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RUN))
      else $error("accepted request not in progress");

   // a new result only ever follows an update cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_RUN))
      else $error("result without a transaction");

   // at most one kind of row update per cycle
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.upd_hit, ctrl.ins_evict, ctrl.ins_fill}))
      else $error("conflicting row updates");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lkv_cell.sv
`default_nettype none

module lkv_cell #(
   parameter int RANK_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lkv_pkg::lkv_ctrl_type ctrl,
   input  wire logic [RANK_W-1:0]    touch_rank,
   input  wire logic [RANK_W-1:0]    victim_rank,
   input  wire lkv_pkg::lkv_link_type link_in,
   input  wire logic [RANK_W-1:0]    rank_prev,
   input  wire logic                 prev_valid,
   output      lkv_pkg::lkv_link_type link_out,
   output      logic [RANK_W-1:0]    rank_out,
   output      logic                 valid_out
);
   import lkv_pkg::*;

   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              valid_ff, valid_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              match, victim, fresh;
   logic [RANK_W-1:0] rank_inc;

   assign match    = valid_ff && (key_ff == ctrl.key);
   assign victim   = valid_ff && (rank_ff == victim_rank);
   // valid cells always form a prefix of the row
   assign fresh    = prev_valid && !valid_ff;
   assign rank_inc = RANK_W'(rank_ff + 1'b1);

   // at most one cell matches, so plain OR merges the row
   assign link_out.hit   = link_in.hit | match;
   assign link_out.value = link_in.value | (match ? value_ff : '0);
   assign rank_out       = rank_prev | (match ? rank_ff : '0);
   assign valid_out      = valid_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (ctrl.upd_hit) begin
         if (match) begin
            value_in = ctrl.value;
            rank_in  = '0;
         end else if (valid_ff && (rank_ff < touch_rank)) begin
            rank_in = rank_inc;
         end
      end else if (ctrl.ins_evict) begin
         if (victim) begin
            key_in   = ctrl.key;
            value_in = ctrl.value;
            rank_in  = '0;
         end else if (valid_ff) begin
            rank_in = rank_inc;
         end
      end else if (ctrl.ins_fill) begin
         if (fresh) begin
            key_in   = ctrl.key;
            value_in = ctrl.value;
            valid_in = 1'b1;
            rank_in  = '0;
         end else if (valid_ff) begin
            rank_in = rank_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

`default_nettype wire
